### rtl/chbd_pkg.sv
// shared types, constants and helper functions of the chunked body decoder
// no dependencies
`timescale 1ns / 1ps

package chbd_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned StatusW = 3;
   localparam int unsigned LenW    = 32;
   localparam int unsigned LineW   = 8;
   localparam int unsigned CsrAddrW = 3;

   localparam logic [StatusW-1:0] ST_OK        = 3'd0;
   localparam logic [StatusW-1:0] ST_PREMATURE = 3'd1;
   localparam logic [StatusW-1:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [StatusW-1:0] ST_TOO_BIG   = 3'd3;
   localparam logic [StatusW-1:0] ST_LINE_LONG = 3'd4;

   localparam logic [0:0] REG_MAX_CHUNK = 1'b0;
   localparam logic [0:0] REG_MAX_LINE  = 1'b1;

   localparam logic [LenW-1:0]  MAX_CHUNK_RESET = '0;
   localparam logic [LineW-1:0] MAX_LINE_RESET  = 8'd255;

   localparam logic [ByteW-1:0] CHAR_LF = 8'h0A;

   typedef struct packed {
      logic [LenW-1:0]  max_chunk_bytes;
      logic [LineW-1:0] max_line_len;
   } chbd_cfg_type;

   typedef struct packed {
      logic [ByteW-1:0]   data_byte;
      logic               body_done;
      logic [StatusW-1:0] status;
   } chbd_result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } chbd_hex_type;

   function automatic chbd_hex_type hex_decode(input logic [ByteW-1:0] c);
      chbd_hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_blank(input logic [ByteW-1:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
   endfunction

endpackage

### rtl/chbd_ifs.sv
// valid/ready channel interfaces for wire bytes in and decoded results out
// payload widths from chbd_pkg
`timescale 1ns / 1ps

interface chbd_req_if;
   import chbd_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] wire_byte;
   logic             wire_end;

   modport source (output valid, output wire_byte, output wire_end, input ready);
   modport sink   (input valid, input wire_byte, input wire_end, output ready);
endinterface

interface chbd_rsp_if;
   import chbd_pkg::*;
   logic               valid;
   logic               ready;
   logic [ByteW-1:0]   data_byte;
   logic               body_done;
   logic [StatusW-1:0] status;

   modport source (output valid, output data_byte, output body_done, output status,
                   input ready);
   modport sink   (input valid, input data_byte, input body_done, input status,
                   output ready);
endinterface

### rtl/chbd_csr.sv
// apb-style configuration registers: chunk size limit and line length limit
// depends on chbd_pkg
`timescale 1ns / 1ps

module chbd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [chbd_pkg::CsrAddrW-1:0]   paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output chbd_pkg::chbd_cfg_type          cfg
);
   import chbd_pkg::*;

   logic [LenW-1:0]  max_chunk_ff, max_chunk_in;
   logic [LineW-1:0] max_line_ff, max_line_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      max_chunk_in = max_chunk_ff;
      max_line_in  = max_line_ff;
      if (wr_en) begin
         case (paddr[2:2])
            REG_MAX_CHUNK: max_chunk_in = pwdata;
            REG_MAX_LINE:  max_line_in  = pwdata[LineW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunk_ff <= MAX_CHUNK_RESET;
         max_line_ff  <= MAX_LINE_RESET;
      end else begin
         max_chunk_ff <= max_chunk_in;
         max_line_ff  <= max_line_in;
      end
   end

   always_comb begin
      case (paddr[2:2])
         REG_MAX_CHUNK: prdata = max_chunk_ff;
         REG_MAX_LINE:  prdata = {{(32 - LineW){1'b0}}, max_line_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.max_chunk_bytes = max_chunk_ff;
   assign cfg.max_line_len    = max_line_ff;

endmodule

### rtl/chbd_parser.sv
// framing state machine: size line parsing, data pass-through, trailer lines, errors
// depends on chbd_pkg
`timescale 1ns / 1ps

module chbd_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [chbd_pkg::ByteW-1:0]      wire_byte,
   input  logic                            wire_end,
   input  chbd_pkg::chbd_cfg_type          cfg,
   output logic                            res_valid,
   output chbd_pkg::chbd_result_type       res
);
   import chbd_pkg::*;

   localparam logic [2:0] PH_SIZE  = 3'd0;
   localparam logic [2:0] PH_DATA  = 3'd1;
   localparam logic [2:0] PH_TRAIL = 3'd2;
   localparam logic [2:0] PH_FINAL = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;
   localparam logic [2:0] PH_ERROR = 3'd5;

   logic [2:0]       phase_ff, phase_in;
   logic [LenW-1:0]  chunk_len_ff, chunk_len_in;
   logic [LenW-1:0]  bytes_left_ff, bytes_left_in;
   logic [LineW-1:0] line_count_ff, line_count_in;
   logic             got_ff, got_in;
   logic             closed_ff, closed_in;
   logic             started_ff, started_in;
   chbd_hex_type     hex;
   logic             is_lf;
   logic             line_full;
   logic [LenW-1:0]  left_dec;

   assign hex       = hex_decode(wire_byte);
   assign is_lf     = (wire_byte == CHAR_LF);
   assign line_full = (line_count_ff >= cfg.max_line_len);
   assign left_dec  = bytes_left_ff - 32'd1;

   always_comb begin
      phase_in      = phase_ff;
      chunk_len_in  = chunk_len_ff;
      bytes_left_in = bytes_left_ff;
      line_count_in = line_count_ff;
      got_in        = got_ff;
      closed_in     = closed_ff;
      started_in    = started_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (accept && phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
         if (wire_end) begin
            phase_in   = PH_ERROR;
            res_valid  = 1'b1;
            res.status = ST_PREMATURE;
         end else begin
            case (phase_ff)
               PH_SIZE: begin
                  if (is_lf) begin
                     if (!got_ff) begin
                        phase_in   = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_SIZE;
                     end else if (cfg.max_chunk_bytes != '0 &&
                                  chunk_len_ff > cfg.max_chunk_bytes) begin
                        phase_in   = PH_ERROR;
                        res_valid  = 1'b1;
                        res.status = ST_TOO_BIG;
                     end else begin
                        line_count_in = '0;
                        got_in        = 1'b0;
                        closed_in     = 1'b0;
                        started_in    = 1'b0;
                        bytes_left_in = chunk_len_ff;
                        phase_in      = (chunk_len_ff == '0) ? PH_FINAL : PH_DATA;
                     end
                  end else if (line_full) begin
                     phase_in   = PH_ERROR;
                     res_valid  = 1'b1;
                     res.status = ST_LINE_LONG;
                  end else begin
                     line_count_in = line_count_ff + 8'd1;
                     if (started_ff || !is_blank(wire_byte)) begin
                        started_in = 1'b1;
                        if (!closed_ff) begin
                           if (!hex.ok) begin
                              closed_in = 1'b1;
                           end else if (chunk_len_ff[LenW-1:LenW-4] != 4'd0) begin
                              phase_in   = PH_ERROR;
                              res_valid  = 1'b1;
                              res.status = ST_TOO_BIG;
                           end else begin
                              chunk_len_in = {chunk_len_ff[LenW-5:0], hex.value};
                              got_in       = 1'b1;
                           end
                        end
                     end
                  end
               end
               PH_DATA: begin
                  bytes_left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in      = PH_TRAIL;
                     line_count_in = '0;
                  end
                  res_valid     = 1'b1;
                  res.data_byte = wire_byte;
               end
               PH_TRAIL, PH_FINAL: begin
                  if (is_lf) begin
                     line_count_in = '0;
                     if (phase_ff == PH_FINAL) begin
                        phase_in      = PH_DONE;
                        res_valid     = 1'b1;
                        res.body_done = 1'b1;
                     end else begin
                        phase_in     = PH_SIZE;
                        chunk_len_in = '0;
                        got_in       = 1'b0;
                        closed_in    = 1'b0;
                        started_in   = 1'b0;
                     end
                  end else if (line_full) begin
                     phase_in   = PH_ERROR;
                     res_valid  = 1'b1;
                     res.status = ST_LINE_LONG;
                  end else begin
                     line_count_in = line_count_ff + 8'd1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         chunk_len_ff  <= '0;
         bytes_left_ff <= '0;
         line_count_ff <= '0;
         got_ff        <= 1'b0;
         closed_ff     <= 1'b0;
         started_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         chunk_len_ff  <= chunk_len_in;
         bytes_left_ff <= bytes_left_in;
         line_count_ff <= line_count_in;
         got_ff        <= got_in;
         closed_ff     <= closed_in;
         started_ff    <= started_in;
      end
   end

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("error phase left");

   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("data phase with no bytes left");

   a_fail_enters_error: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != ST_OK |=> phase_ff == PH_ERROR)
      else $error("error result without error phase");

   a_done_result_once: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> !res_valid)
      else $error("result after body done");

endmodule

### rtl/chbd_out_buf.sv
// result register with one skid entry so one more input transfer can be taken under output stall
// depends on chbd_pkg
`timescale 1ns / 1ps

module chbd_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  chbd_pkg::chbd_result_type  push_data,
   output logic                       can_accept,
   output logic                       out_valid,
   input  logic                       out_ready,
   output chbd_pkg::chbd_result_type  out_data
);
   import chbd_pkg::*;

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   chbd_result_type out_ff, out_in;
   chbd_result_type skid_ff, skid_in;
   logic            pop;

   assign pop        = out_valid_ff && out_ready;
   assign can_accept = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without result register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("transfer into full buffer");

   a_skid_held: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !pop |=> skid_valid_ff && $stable(skid_ff))
      else $error("buffered result lost");

endmodule

### rtl/http_chunked_body_decoder.sv
// top level: one wire byte in per cycle, at most one decoded result out
// latency: a result is on the rsp channel the cycle after its byte's transfer when the
// result register is free, else once the results ahead of it have left
// throughput: one byte per cycle; ready drops only while both result slots are full
// reset (synchronous, active high) returns framing and error state to the start
// and the limits to their defaults; depends on chbd_pkg, chbd_ifs, chbd_csr,
// chbd_parser, chbd_out_buf
`timescale 1ns / 1ps

module http_chunked_body_decoder (
   input  logic                            clock,
   input  logic                            reset,
   chbd_req_if.sink                        req_chan,
   chbd_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [chbd_pkg::CsrAddrW-1:0]   paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import chbd_pkg::*;

   chbd_cfg_type    cfg;
   chbd_result_type res;
   chbd_result_type out_data;
   logic            res_valid;
   logic            can_accept;
   logic            accept;

   assign req_chan.ready = can_accept;
   assign accept         = req_chan.valid && can_accept;

   chbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   chbd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .wire_byte (req_chan.wire_byte),
      .wire_end  (req_chan.wire_end),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   chbd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .can_accept (can_accept),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (out_data)
   );

   assign rsp_chan.data_byte = out_data.data_byte;
   assign rsp_chan.body_done = out_data.body_done;
   assign rsp_chan.status    = out_data.status;

endmodule

### tb/sv/http_chunked_body_decoder_tb.sv
// self-checking testbench for http_chunked_body_decoder: wire bytes in, decoded bytes out
// depends on chbd_pkg, chbd_ifs and the decoder rtl
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
   import chbd_pkg::*;

   localparam int ITEMS       = 1650;
   localparam int HOLD_CYCLES = 80;

   typedef enum logic [2:0] {
      DEC_SIZE, DEC_DATA, DEC_TRAIL, DEC_FINAL, DEC_DONE, DEC_ERROR
   } dec_phase_type;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   chbd_req_if req_if();
   chbd_rsp_if rsp_if();

   http_chunked_body_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // register copies and decoder state as the predictor sees it
   logic [LenW-1:0]  lim_chunk = MAX_CHUNK_RESET;
   logic [LineW-1:0] lim_line  = MAX_LINE_RESET;
   dec_phase_type    dec_phase = DEC_SIZE;
   logic [LenW-1:0]  dec_len   = '0;
   logic [LenW-1:0]  dec_left  = '0;
   logic [LineW-1:0] dec_line  = '0;
   logic             dec_got = 1'b0, dec_closed = 1'b0, dec_started = 1'b0;

   chbd_result_type decoded_q[$];
   chbd_result_type rsp_want;
   logic [7:0]      pend_q[$];

   int errors     = 0;
   int items_sent = 0;
   int rsp_stall;
   bit rush     = 1'b0;
   bit hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("http_chunked_body_decoder_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function automatic void add_body_result(input logic [7:0] b, input logic done,
                                           input logic [StatusW-1:0] st);
      chbd_result_type r;
      r.data_byte = b;
      r.body_done = done;
      r.status    = st;
      decoded_q.push_back(r);
   endfunction

   function automatic void flag_error(input logic [StatusW-1:0] st);
      dec_phase = DEC_ERROR;
      add_body_result(8'h00, 1'b0, st);
   endfunction

   function automatic void decode_wire(input logic [7:0] c, input logic eos);
      int v;
      if (dec_phase == DEC_DONE || dec_phase == DEC_ERROR) return;
      if (eos) begin
         flag_error(ST_PREMATURE);
         return;
      end
      case (dec_phase)
         DEC_SIZE: begin
            if (c == CHAR_LF) begin
               if (!dec_got) begin
                  flag_error(ST_BAD_SIZE);
               end else if (lim_chunk != 0 && dec_len > lim_chunk) begin
                  flag_error(ST_TOO_BIG);
               end else begin
                  dec_line    = '0;
                  dec_got     = 1'b0;
                  dec_closed  = 1'b0;
                  dec_started = 1'b0;
                  if (dec_len == 0) begin
                     dec_phase = DEC_FINAL;
                  end else begin
                     dec_left  = dec_len;
                     dec_phase = DEC_DATA;
                  end
               end
            end else if (dec_line >= lim_line) begin
               flag_error(ST_LINE_LONG);
            end else begin
               dec_line = dec_line + 1'b1;
               if (dec_started || !(c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D})) begin
                  dec_started = 1'b1;
                  if (!dec_closed) begin
                     v = nibble_of(c);
                     if (v < 0) begin
                        dec_closed = 1'b1;
                     end else if (dec_len > 32'h0FFF_FFFF) begin
                        flag_error(ST_TOO_BIG);
                     end else begin
                        dec_len = {dec_len[LenW-5:0], v[3:0]};
                        dec_got = 1'b1;
                     end
                  end
               end
            end
         end
         DEC_DATA: begin
            dec_left = dec_left - 1'b1;
            if (dec_left == 0) begin
               dec_phase = DEC_TRAIL;
               dec_line  = '0;
            end
            add_body_result(c, 1'b0, ST_OK);
         end
         DEC_TRAIL, DEC_FINAL: begin
            if (c == CHAR_LF) begin
               dec_line = '0;
               if (dec_phase == DEC_FINAL) begin
                  dec_phase = DEC_DONE;
                  add_body_result(8'h00, 1'b1, ST_OK);
               end else begin
                  dec_phase   = DEC_SIZE;
                  dec_len     = '0;
                  dec_got     = 1'b0;
                  dec_closed  = 1'b0;
                  dec_started = 1'b0;
               end
            end else if (dec_line >= lim_line) begin
               flag_error(ST_LINE_LONG);
            end else begin
               dec_line = dec_line + 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- wire text

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 10) return 8'h30 + 8'(nib);
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 4))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0B;
         3: return 8'h0C;
         default: return 8'h0D;
      endcase
   endfunction

   function automatic logic [7:0] non_lf_byte();
      logic [7:0] b;
      if ($urandom_range(0, 2) == 0) return 8'h0D;
      do b = 8'($urandom); while (b == CHAR_LF);
      return b;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      if ($urandom_range(0, 2) == 0) return 8'h3B;
      do b = 8'($urandom); while (b == CHAR_LF || nibble_of(b) >= 0);
      return b;
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) pend_q.push_back(s[i]);
   endfunction

   // size line within the current line limit; fill makes it exactly that long
   function automatic void put_size_line(input logic [31:0] size, input bit fill);
      logic [7:0]  digits[$];
      logic [31:0] v;
      int room, nb, nz, nt;
      v = size;
      do begin
         digits.push_front(hex_char(v[3:0]));
         v = v >> 4;
      end while (v != 0);
      room = int'(lim_line) - digits.size();
      if (room < 0) room = 0;
      if (fill) begin
         nb = $urandom_range(0, room < 3 ? room : 3);
         nz = $urandom_range(0, room - nb);
         nt = room - nb - nz;
      end else begin
         nb = ($urandom_range(0, 2) == 0) ? $urandom_range(0, room < 2 ? room : 2) : 0;
         nz = ($urandom_range(0, 3) == 0) ?
              $urandom_range(0, room - nb < 3 ? room - nb : 3) : 0;
         nt = $urandom_range(0, room - nb - nz < 6 ? room - nb - nz : 6);
      end
      repeat (nb) pend_q.push_back(blank_byte());
      repeat (nz) pend_q.push_back(8'h30);
      foreach (digits[i]) pend_q.push_back(digits[i]);
      if (nt > 0) pend_q.push_back(non_hex_byte());
      for (int i = 1; i < nt; i++) pend_q.push_back(non_lf_byte());
      pend_q.push_back(CHAR_LF);
   endfunction

   function automatic void put_trailer(input bit fill);
      int n;
      if (fill) n = lim_line;
      else n = $urandom_range(0, 1) ? 1 : $urandom_range(0, lim_line < 3 ? lim_line : 3);
      repeat (n) pend_q.push_back(non_lf_byte());
      pend_q.push_back(CHAR_LF);
   endfunction

   function automatic void put_chunk(input logic [31:0] size, input bit fill);
      put_size_line(size, fill);
      repeat (size) pend_q.push_back(8'($urandom));
      put_trailer(fill);
   endfunction

   function automatic logic [31:0] pick_size();
      logic [31:0] s;
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      if (lim_line == 1 && s > 15) s = $urandom_range(1, 15);
      if (lim_chunk != 0 && s > lim_chunk) s = lim_chunk;
      return s;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic [7:0] b, input logic eos);
      int gap;
      gap = rush ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock) req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.wire_byte <= b;
      req_if.wire_end  <= eos;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      decode_wire(b, eos);
      items_sent++;
   endtask

   task automatic send_pending();
      while (pend_q.size() != 0) send_item(pend_q.pop_front(), 1'b0);
   endtask

   // stop sending and let every expected result drain
   task automatic settle();
      @(negedge clock) req_if.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_check(input logic [0:0] idx, input logic [31:0] want);
      logic [31:0] mask;
      mask = (idx == REG_MAX_LINE) ? 32'h0000_00FF : 32'hFFFF_FFFF;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if ((prdata & mask) !== (want & mask)) begin
         $display("%0t ns: register %0d read expected %h got %h", $time, idx,
                  want & mask, prdata & mask);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [31:0] value);
      settle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == REG_MAX_CHUNK) lim_chunk = value;
      else lim_line = value[LineW-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      csr_check(idx, value);
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_req) begin
            rsp_stall = HOLD_CYCLES;
            hold_req  = 1'b0;
         end else begin
            rsp_stall = rush ? 0 : $urandom_range(0, 3);
         end
         if (rsp_stall > 0) begin
            @(negedge clock) rsp_if.ready <= 1'b0;
            repeat (rsp_stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (decoded_q.size() == 0) begin
            $display("%0t ns: unexpected transfer, expected none, got data %h done %b status %0d",
                     $time, rsp_if.data_byte, rsp_if.body_done, rsp_if.status);
            errors++;
         end else begin
            rsp_want = decoded_q.pop_front();
            if (rsp_if.data_byte !== rsp_want.data_byte) begin
               $display("%0t ns: data_byte expected %h got %h", $time,
                        rsp_want.data_byte, rsp_if.data_byte);
               errors++;
            end
            if (rsp_if.body_done !== rsp_want.body_done) begin
               $display("%0t ns: body_done expected %b got %b", $time,
                        rsp_want.body_done, rsp_if.body_done);
               errors++;
            end
            if (rsp_if.status !== rsp_want.status) begin
               $display("%0t ns: status expected %0d got %0d", $time,
                        rsp_want.status, rsp_if.status);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      csr_check(REG_MAX_CHUNK, MAX_CHUNK_RESET);
      csr_check(REG_MAX_LINE, {24'h0, MAX_LINE_RESET});
   endtask

   // blanks before the size, extension, non-hex end of digits, extreme data bytes
   task automatic test_directed_edges();
      put_text(" \013\014\015\t3;e\015\n");
      pend_q.push_back(8'h00);
      pend_q.push_back(8'hFF);
      pend_q.push_back(CHAR_LF);
      put_text("\015\n1G\n");
      pend_q.push_back(8'hA5);
      pend_q.push_back(CHAR_LF);
      send_pending();
   endtask

   // chunks at exactly the size limit, lines at exactly the length limit
   task automatic test_limit_edges();
      logic [31:0] n;
      csr_write(REG_MAX_LINE, 32'd1);
      csr_write(REG_MAX_CHUNK, 32'd1);
      put_chunk(32'd1, 1'b1);
      put_chunk(32'd1, 1'b0);
      send_pending();
      n = $urandom_range(2, 40);
      csr_write(REG_MAX_CHUNK, n);
      csr_write(REG_MAX_LINE, $urandom_range(2, 40));
      put_chunk(n, 1'b1);
      send_pending();
      csr_write(REG_MAX_CHUNK, 32'hFFFF_FFFF);
      csr_write(REG_MAX_LINE, 32'd255);
      put_chunk(pick_size(), 1'b1);
      send_pending();
   endtask

   task automatic test_random_bodies();
      int chunk_n;
      chunk_n = 0;
      while (items_sent < ITEMS) begin
         if (chunk_n % 8 == 0) begin
            case ($urandom_range(0, 5))
               1: csr_write(REG_MAX_CHUNK, 32'd1);
               2: csr_write(REG_MAX_CHUNK, 32'hFFFF_FFFF);
               3: csr_write(REG_MAX_CHUNK, $urandom_range(2, 80));
               4: csr_write(REG_MAX_CHUNK, $urandom);
               default: csr_write(REG_MAX_CHUNK, 32'd0);
            endcase
            case ($urandom_range(0, 4))
               0: csr_write(REG_MAX_LINE, 32'd1);
               2: csr_write(REG_MAX_LINE, $urandom_range(2, 12));
               3: csr_write(REG_MAX_LINE, $urandom_range(13, 254));
               default: csr_write(REG_MAX_LINE, 32'd255);
            endcase
         end
         if ($urandom_range(0, 5) == 0) rush = !rush;
         put_chunk(pick_size(), $urandom_range(0, 19) == 0);
         send_pending();
         chunk_n++;
      end
      rush = 1'b0;
   endtask

   // results held back long enough that the decoder stops taking bytes
   task automatic test_result_backpressure();
      csr_write(REG_MAX_CHUNK, 32'd0);
      csr_write(REG_MAX_LINE, 32'd255);
      rush     = 1'b1;
      hold_req = 1'b1;
      put_chunk(32'd64, 1'b0);
      send_pending();
      rush = 1'b0;
   endtask

   // one way of ending the body per run, then bytes and end marks, ignored once the body has ended
   task automatic test_body_end();
      logic [StatusW-1:0] ending;
      logic [31:0]        m;
      int                 n;
      csr_write(REG_MAX_LINE, 32'd255);
      csr_write(REG_MAX_CHUNK, 32'd0);
      ending = 3'($urandom_range(0, 4));
      case (ending)
         ST_OK: begin
            case ($urandom_range(0, 2))
               0: put_text("0\015\n");
               1: put_text("0x7f\n");
               default: put_text(" 000;end=1\015\n");
            endcase
            put_trailer(1'b0);
         end
         ST_PREMATURE: begin
            put_chunk(pick_size(), 1'b0);
            n = $urandom_range(0, pend_q.size() - 1);
            while (pend_q.size() > n) pend_q.delete(pend_q.size() - 1);
         end
         ST_BAD_SIZE: begin
            case ($urandom_range(0, 4))
               0: put_text("\015\n");
               1: put_text("-5\015\n");
               2: put_text("+1\n");
               3: put_text(" \t;ext\n");
               default: put_text("x12\n");
            endcase
         end
         ST_TOO_BIG: begin
            if ($urandom_range(0, 1)) begin
               m = $urandom_range(1, 32'hFFFF_FFFE);
               csr_write(REG_MAX_CHUNK, m);
               put_size_line(m + 1, 1'b0);
            end else begin
               put_text("fedcba987\015\n");
            end
         end
         default: begin
            csr_write(REG_MAX_LINE, $urandom_range(1, 20));
            if ($urandom_range(0, 1)) put_chunk($urandom_range(1, 9), 1'b0);
            while (pend_q.size() != 0 && pend_q[pend_q.size() - 1] == CHAR_LF &&
                   $urandom_range(0, 1) == 5)
               ;
            if (pend_q.size() != 0) pend_q.delete(pend_q.size() - 1);
            repeat (int'(lim_line) + 1) pend_q.push_back(non_lf_byte());
            pend_q.push_back(CHAR_LF);
         end
      endcase
      send_pending();
      repeat (5) send_item(8'($urandom), 1'($urandom_range(0, 1)));
      send_item(8'($urandom), 1'b1);
   endtask

   initial begin
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_if.valid     = 1'b0;
      req_if.wire_byte = '0;
      req_if.wire_end  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_reset_values();
      test_directed_edges();
      test_limit_edges();
      test_random_bodies();
      test_result_backpressure();
      test_body_end();
      settle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("http_chunked_body_decoder_tb: clean");
      end else begin
         $display("http_chunked_body_decoder_tb: errors");
      end
      $finish;
   end

endmodule

### http_chunked_body_decoder.f
rtl/chbd_pkg.sv
rtl/chbd_ifs.sv
rtl/chbd_csr.sv
rtl/chbd_parser.sv
rtl/chbd_out_buf.sv
rtl/http_chunked_body_decoder.sv
tb/sv/http_chunked_body_decoder_tb.sv
